@@ hdl/qrs_pkg.sv @@
// Shared types and constants of the quadratic root solver.
`default_nettype none

package qrs_pkg;

    // Default fraction bits of the fixed-point coefficients and roots
    localparam int FRAC_BITS_DEF = 16;

    // Datapath widths that do not depend on the fraction bits
    localparam int MAG_W   = 32;   // coefficient magnitude
    localparam int PROD_W  = 64;   // product of two magnitudes
    localparam int RAD_W   = 66;   // radicand of the square root
    localparam int ROOT_W  = 33;   // floor square root
    localparam int REM_W   = 37;   // square root partial remainder
    localparam int NUM_W   = 34;   // division numerator and divisor before scaling
    localparam int QUO_W   = 34;   // quotient bits kept; the top bit flags a huge quotient
    localparam int CLIP_W  = 16;
    localparam int SQ_N    = ROOT_W;
    localparam int DIV_N   = QUO_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

    // Solution class of one coefficient triple
    typedef enum logic [2:0] {
        K_NONE,      // no real root
        K_LIN,       // a zero: -c/b twice
        K_CZERO,     // c zero: 0 and -b/a
        K_BZS,       // b zero, a and c same sign, clipped: both zero
        K_BZO,       // b zero, a and c opposite sign: +/- sqrt(-ac)/a
        K_DZERO,     // zero discriminant: -b/(2a) twice
        K_DPOS       // positive discriminant: q/a and c/q
    } kind_t;

    // Per-item context carried along the pipeline
    typedef struct packed {
        logic [MAG_W-1:0] am;
        logic [MAG_W-1:0] bm;
        logic [MAG_W-1:0] cm;
        logic             an;
        logic             bn;
        logic             cn;
        kind_t            kind;
    } ctx_t;

endpackage

`default_nettype wire

@@ hdl/quadratic_root_solver_core.sv @@
// Quadratic root solver: real roots of a*x^2 + b*x + c in signed fixed point.
//
// Input channel in_valid/in_ready carries coef_a, coef_b, coef_c; output
// channel out_valid/out_ready carries root_first, root_second, first_valid,
// second_valid and overflow. A transfer happens when valid and ready are
// both high at a rising clock edge. An item passes 3 front stages
// (magnitudes, products, discriminant), 33 square root cells (one root bit
// each), one divider setup stage, 34 division cells (one quotient bit of
// both dividers each) and one output stage. Throughput is one item per
// cycle while the receiver does not stall; every cell holds its own item,
// so the chain runs full. The user writes the configuration through
// cfg_write/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce it. Reset sets clip_threshold and order_mode
// to 1 and empties the pipeline. When the receiver stalls, the output stage
// holds its result, each cell holds while its neighbor downstream is full,
// bubbles close up, and in_ready drops only once every cell is occupied.
`default_nettype none

module quadratic_root_solver_core #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [qrs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [qrs_pkg::CLIP_W-1:0]            cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [qrs_pkg::MAG_W-1:0]      coef_a,
    input  wire logic signed [qrs_pkg::MAG_W-1:0]      coef_b,
    input  wire logic signed [qrs_pkg::MAG_W-1:0]      coef_c,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [qrs_pkg::MAG_W-1:0]           root_first,
    output logic signed [qrs_pkg::MAG_W-1:0]           root_second,
    output logic                                       first_valid,
    output logic                                       second_valid,
    output logic                                       overflow
);

    localparam int MW  = qrs_pkg::MAG_W;
    localparam int NW  = qrs_pkg::NUM_W;
    localparam int QW  = qrs_pkg::QUO_W;
    localparam int DW  = FRAC_BITS + NW;
    localparam int SN  = qrs_pkg::SQ_N;
    localparam int DN  = qrs_pkg::DIV_N;

    typedef struct packed {
        logic        neg;
        logic [QW-1:0] mag;
    } sroot_t;

    typedef struct packed {
        logic [MW-1:0] val;
        logic          ovf;
    } sat_t;

    // Clamp a signed quotient to the 32-bit range
    function automatic sat_t saturate(input sroot_t r);
        sat_t s;
        logic big;
        big = r.mag[QW-1] || (r.mag[QW-2:0] > (QW-1)'({1'b1, {(MW-1){1'b0}}}));
        s.ovf = 1'b0;
        s.val = '0;
        if (r.neg)
        begin
            s.ovf = big;
            s.val = big ? {1'b1, {(MW-1){1'b0}}} : MW'(-r.mag[MW-1:0]);
        end
        else
        begin
            s.ovf = r.mag[QW-1:MW-1] != '0;
            s.val = s.ovf ? {1'b0, {(MW-1){1'b1}}} : r.mag[MW-1:0];
        end
        return s;
    endfunction

    // Configuration registers
    logic [qrs_pkg::CLIP_W-1:0] clip_reg;
    logic                       order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg  <= qrs_pkg::CLIP_W'(1);
            order_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qrs_pkg::REG_CLIP:  clip_reg  <= cfg_data;
                qrs_pkg::REG_ORDER: order_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Square root chain links
    logic                          sq_valid [0:SN];
    logic                          sq_ready [0:SN];
    qrs_pkg::ctx_t                 sq_ctx   [0:SN];
    logic [qrs_pkg::RAD_W-1:0]     sq_rad   [0:SN];
    logic [qrs_pkg::REM_W-1:0]     sq_rem   [0:SN];
    logic [qrs_pkg::ROOT_W-1:0]    sq_root  [0:SN];

    qrs_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .clip      (clip_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .out_valid (sq_valid[0]),
        .out_ready (sq_ready[0]),
        .out_ctx   (sq_ctx[0]),
        .out_rad   (sq_rad[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < SN; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_ctx    (sq_ctx[i]),
            .in_rad    (sq_rad[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_ctx   (sq_ctx[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1])
        );
    end

    // Division chain links
    logic                  dv_valid [0:DN];
    logic                  dv_ready [0:DN];
    qrs_pkg::ctx_t         dv_ctx   [0:DN];
    logic [DW-1:0]         dv_xrem  [0:DN];
    logic [NW-1:0]         dv_xdiv  [0:DN];
    logic [QW-1:0]         dv_xq    [0:DN];
    logic [DW-1:0]         dv_yrem  [0:DN];
    logic [NW-1:0]         dv_ydiv  [0:DN];
    logic [QW-1:0]         dv_yq    [0:DN];

    // Setup stage: pick numerators and divisors of both dividers
    logic            su_valid_reg;
    qrs_pkg::ctx_t   su_ctx_reg;
    logic [DW-1:0]   su_xnum_reg, su_ynum_reg;
    logic [NW-1:0]   su_xdiv_reg, su_ydiv_reg;
    logic [NW-1:0]   s, twoq, am2, xn, xd, yn, yd;
    qrs_pkg::ctx_t   sc;

    assign sc   = sq_ctx[SN];
    assign s    = NW'(sq_root[SN]);
    assign twoq = NW'(sc.bm) + s;
    assign am2  = NW'(sc.am) << 1;
    assign sq_ready[SN] = !su_valid_reg || dv_ready[0];

    always_comb
    begin
        xn = '0;
        xd = NW'(1);
        yn = '0;
        yd = NW'(1);
        case (sc.kind)
            qrs_pkg::K_LIN:
            begin
                xn = NW'(sc.cm);
                xd = NW'(sc.bm);
            end
            qrs_pkg::K_CZERO:
            begin
                xn = NW'(sc.bm);
                xd = NW'(sc.am);
            end
            qrs_pkg::K_BZO:
            begin
                xn = s;
                xd = NW'(sc.am);
            end
            qrs_pkg::K_DZERO:
            begin
                xn = NW'(sc.bm);
                xd = am2;
            end
            qrs_pkg::K_DPOS:
            begin
                xn = twoq;
                xd = am2;
                yn = {1'b0, sc.cm, 1'b0};
                yd = twoq;
            end
            default:
            begin
                xn = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_valid_reg <= 1'b0;
        end
        else if (sq_ready[SN])
        begin
            su_valid_reg <= sq_valid[SN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_valid[SN] && sq_ready[SN])
        begin
            su_ctx_reg  <= sc;
            su_xnum_reg <= DW'(xn) << FRAC_BITS;
            su_ynum_reg <= DW'(yn) << FRAC_BITS;
            su_xdiv_reg <= xd;
            su_ydiv_reg <= yd;
        end
    end

    assign dv_valid[0] = su_valid_reg;
    assign dv_ctx[0]   = su_ctx_reg;
    assign dv_xrem[0]  = su_xnum_reg;
    assign dv_xdiv[0]  = su_xdiv_reg;
    assign dv_xq[0]    = '0;
    assign dv_yrem[0]  = su_ynum_reg;
    assign dv_ydiv[0]  = su_ydiv_reg;
    assign dv_yq[0]    = '0;

    for (genvar k = 0; k < DN; k++)
    begin : g_div
        qrs_div_cell #(
            .DW    (DW),
            .SHIFT (DN - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .in_ctx    (dv_ctx[k]),
            .in_xrem   (dv_xrem[k]),
            .in_xdiv   (dv_xdiv[k]),
            .in_xq     (dv_xq[k]),
            .in_yrem   (dv_yrem[k]),
            .in_ydiv   (dv_ydiv[k]),
            .in_yq     (dv_yq[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .out_ctx   (dv_ctx[k+1]),
            .out_xrem  (dv_xrem[k+1]),
            .out_xdiv  (dv_xdiv[k+1]),
            .out_xq    (dv_xq[k+1]),
            .out_yrem  (dv_yrem[k+1]),
            .out_ydiv  (dv_ydiv[k+1]),
            .out_yq    (dv_yq[k+1])
        );
    end

    // Output stage: signs, saturation and ordering
    logic                   out_valid_reg;
    logic [MW-1:0]          r1_reg, r2_reg;
    logic                   ok_reg, ovf_reg;
    qrs_pkg::ctx_t          fc;
    sroot_t                 r1, r2, rx, ry, rz;
    sat_t                   s1, s2;
    logic signed [MW-1:0]   v1, v2, o1, o2;
    logic                   ok;

    assign fc = dv_ctx[DN];
    assign dv_ready[DN] = !out_valid_reg || out_ready;

    always_comb
    begin
        rz = '0;
        rx = '0;
        ry = '0;
        r1 = '0;
        r2 = '0;
        ok = 1'b1;
        rx.mag = dv_xq[DN];
        ry.mag = dv_yq[DN];
        case (fc.kind)
            qrs_pkg::K_LIN:
            begin
                rx.neg = fc.cn == fc.bn;
                r1 = rx;
                r2 = rx;
            end
            qrs_pkg::K_CZERO:
            begin
                rx.neg = fc.an == fc.bn;
                if (fc.bn)
                begin
                    r1 = rx;
                    r2 = rz;
                end
                else
                begin
                    r1 = rz;
                    r2 = rx;
                end
            end
            qrs_pkg::K_BZS:
            begin
                r1 = rz;
                r2 = rz;
            end
            qrs_pkg::K_BZO:
            begin
                r1 = rx;
                r1.neg = fc.an;
                r2 = rx;
                r2.neg = !fc.an;
            end
            qrs_pkg::K_DZERO:
            begin
                rx.neg = fc.an == fc.bn;
                r1 = rx;
                r2 = rx;
            end
            qrs_pkg::K_DPOS:
            begin
                rx.neg = fc.an == fc.bn;
                ry.neg = fc.cn == fc.bn;
                if (fc.bn)
                begin
                    r1 = rx;
                    r2 = ry;
                end
                else
                begin
                    r1 = ry;
                    r2 = rx;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign s1 = saturate(r1);
    assign s2 = saturate(r2);
    assign v1 = s1.val;
    assign v2 = s2.val;

    // If order_reg is set, put the (smaller) nonnegative root first
    always_comb
    begin
        o1 = v1;
        o2 = v2;
        if (order_reg)
        begin
            if (!v1[MW-1] && !v2[MW-1])
            begin
                if (v1 > v2)
                begin
                    o1 = v2;
                    o2 = v1;
                end
            end
            else if (v1[MW-1])
            begin
                o1 = v2;
                o2 = v1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dv_ready[DN])
        begin
            out_valid_reg <= dv_valid[DN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_valid[DN] && dv_ready[DN])
        begin
            r1_reg  <= ok ? o1 : '0;
            r2_reg  <= ok ? o2 : '0;
            ok_reg  <= ok;
            ovf_reg <= ok && (s1.ovf || s2.ovf);
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_first   = r1_reg;
    assign root_second  = r2_reg;
    assign first_valid  = ok_reg;
    assign second_valid = ok_reg;
    assign overflow     = ovf_reg;

endmodule

`default_nettype wire

@@ hdl/qrs_prep.sv @@
// Front stages: magnitudes, products, discriminant and solution class.
`default_nettype none

module qrs_prep #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [qrs_pkg::CLIP_W-1:0]        clip,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [qrs_pkg::MAG_W-1:0]  coef_a,
    input  wire logic signed [qrs_pkg::MAG_W-1:0]  coef_b,
    input  wire logic signed [qrs_pkg::MAG_W-1:0]  coef_c,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output qrs_pkg::ctx_t                          out_ctx,
    output logic [qrs_pkg::RAD_W-1:0]              out_rad
);

    localparam int MW  = qrs_pkg::MAG_W;
    localparam int PW  = qrs_pkg::PROD_W;
    localparam int RW  = qrs_pkg::RAD_W;
    localparam int CAW = qrs_pkg::CLIP_W + MW;
    localparam int LW  = MW + FRAC_BITS + qrs_pkg::CLIP_W;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                s1_ready, s2_ready, s3_ready;
    qrs_pkg::ctx_t       s1_ctx_reg, s2_ctx_reg, s3_ctx_reg;
    qrs_pkg::ctx_t       s3_ctx_next;
    logic [PW-1:0]       s2_bb_reg, s2_p_reg;
    logic [CAW-1:0]      s2_clipam_reg;
    logic [RW-1:0]       s3_rad_reg;

    logic [MW-1:0]       am, bm, cm;
    logic [RW-1:0]       bb, p4, dsum, ddif, drev, d, rad;
    logic                opp, ge, dneg, clip_ok, bzs_ok, az, bz, cz;
    qrs_pkg::kind_t      kind;

    // Hold each stage while the next one is full
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Take magnitudes and signs of the coefficients
    assign am = coef_a[MW-1] ? MW'(-coef_a) : coef_a;
    assign bm = coef_b[MW-1] ? MW'(-coef_b) : coef_b;
    assign cm = coef_c[MW-1] ? MW'(-coef_c) : coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: register magnitudes
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_ctx_reg.am   <= am;
            s1_ctx_reg.bm   <= bm;
            s1_ctx_reg.cm   <= cm;
            s1_ctx_reg.an   <= coef_a[MW-1];
            s1_ctx_reg.bn   <= coef_b[MW-1];
            s1_ctx_reg.cn   <= coef_c[MW-1];
            s1_ctx_reg.kind <= qrs_pkg::K_NONE;
        end
    end

    // Stage 2: products b*b, a*c and clip*a
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_ctx_reg    <= s1_ctx_reg;
            s2_bb_reg     <= PW'(s1_ctx_reg.bm) * PW'(s1_ctx_reg.bm);
            s2_p_reg      <= PW'(s1_ctx_reg.am) * PW'(s1_ctx_reg.cm);
            s2_clipam_reg <= CAW'(clip) * CAW'(s1_ctx_reg.am);
        end
    end

    // Stage 3: discriminant, clipping and classification
    assign bb      = RW'(s2_bb_reg);
    assign p4      = {s2_p_reg, 2'b00};
    assign opp     = s2_ctx_reg.an != s2_ctx_reg.cn;
    assign ge      = bb >= p4;
    assign dsum    = bb + p4;
    assign ddif    = bb - p4;
    assign drev    = p4 - bb;
    assign d       = opp ? dsum : (ge ? ddif : drev);
    assign dneg    = !opp && !ge;
    assign clip_ok = d < (RW'(clip) << FRAC_BITS);
    assign bzs_ok  = (LW'(s2_ctx_reg.cm) << FRAC_BITS) < LW'(s2_clipam_reg);
    assign az      = s2_ctx_reg.am == '0;
    assign bz      = s2_ctx_reg.bm == '0;
    assign cz      = s2_ctx_reg.cm == '0;

    always_comb
    begin
        kind = qrs_pkg::K_NONE;
        rad  = '0;
        if (az && bz)
        begin
            kind = qrs_pkg::K_NONE;
        end
        else if (az)
        begin
            kind = qrs_pkg::K_LIN;
        end
        else if (cz)
        begin
            kind = qrs_pkg::K_CZERO;
        end
        else if (bz)
        begin
            if (opp)
            begin
                kind = qrs_pkg::K_BZO;
                rad  = RW'(s2_p_reg);
            end
            else
            begin
                kind = bzs_ok ? qrs_pkg::K_BZS : qrs_pkg::K_NONE;
            end
        end
        else if (dneg && !clip_ok)
        begin
            kind = qrs_pkg::K_NONE;
        end
        else if (dneg || d == '0)
        begin
            kind = qrs_pkg::K_DZERO;
        end
        else
        begin
            kind = qrs_pkg::K_DPOS;
            rad  = d;
        end
    end

    // Attach the class to the carried context
    always_comb
    begin
        s3_ctx_next      = s2_ctx_reg;
        s3_ctx_next.kind = kind;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            s3_ctx_reg <= s3_ctx_next;
            s3_rad_reg <= rad;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_ctx   = s3_ctx_reg;
    assign out_rad   = s3_rad_reg;

endmodule

`default_nettype wire

@@ hdl/qrs_sqrt_cell.sv @@
// One cell of the square root chain: one root bit per cell.
`default_nettype none

module qrs_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire qrs_pkg::ctx_t                 in_ctx,
    input  wire logic [qrs_pkg::RAD_W-1:0]     in_rad,
    input  wire logic [qrs_pkg::REM_W-1:0]     in_rem,
    input  wire logic [qrs_pkg::ROOT_W-1:0]    in_root,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output qrs_pkg::ctx_t                      out_ctx,
    output logic [qrs_pkg::RAD_W-1:0]          out_rad,
    output logic [qrs_pkg::REM_W-1:0]          out_rem,
    output logic [qrs_pkg::ROOT_W-1:0]         out_root
);

    localparam int RW = qrs_pkg::RAD_W;
    localparam int EW = qrs_pkg::REM_W;
    localparam int TW = qrs_pkg::ROOT_W;

    logic            valid_reg;
    qrs_pkg::ctx_t   ctx_reg;
    logic [RW-1:0]   rad_reg;
    logic [EW-1:0]   rem_reg;
    logic [TW-1:0]   root_reg;

    logic [EW-1:0]   rem2, trial;
    logic            take;

    // Bring down the next two radicand bits and try the next root bit
    assign rem2  = {in_rem[EW-3:0], in_rad[RW-1 -: 2]};
    assign trial = EW'({in_root, 2'b01});
    assign take  = rem2 >= trial;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctx_reg  <= in_ctx;
            rad_reg  <= {in_rad[RW-3:0], 2'b00};
            rem_reg  <= take ? rem2 - trial : rem2;
            root_reg <= {in_root[TW-2:0], take};
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

`default_nettype wire

@@ hdl/qrs_div_cell.sv @@
// One cell of the dual division chain: one quotient bit of each divider.
`default_nettype none

module qrs_div_cell #(
    parameter int DW    = qrs_pkg::FRAC_BITS_DEF + qrs_pkg::NUM_W,
    parameter int SHIFT = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire qrs_pkg::ctx_t                 in_ctx,
    input  wire logic [DW-1:0]                 in_xrem,
    input  wire logic [qrs_pkg::NUM_W-1:0]     in_xdiv,
    input  wire logic [qrs_pkg::QUO_W-1:0]     in_xq,
    input  wire logic [DW-1:0]                 in_yrem,
    input  wire logic [qrs_pkg::NUM_W-1:0]     in_ydiv,
    input  wire logic [qrs_pkg::QUO_W-1:0]     in_yq,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output qrs_pkg::ctx_t                      out_ctx,
    output logic [DW-1:0]                      out_xrem,
    output logic [qrs_pkg::NUM_W-1:0]          out_xdiv,
    output logic [qrs_pkg::QUO_W-1:0]          out_xq,
    output logic [DW-1:0]                      out_yrem,
    output logic [qrs_pkg::NUM_W-1:0]          out_ydiv,
    output logic [qrs_pkg::QUO_W-1:0]          out_yq
);

    localparam int NW = qrs_pkg::NUM_W;
    localparam int QW = qrs_pkg::QUO_W;
    localparam int CW = DW + QW;

    logic            valid_reg;
    qrs_pkg::ctx_t   ctx_reg;
    logic [DW-1:0]   xrem_reg, yrem_reg;
    logic [NW-1:0]   xdiv_reg, ydiv_reg;
    logic [QW-1:0]   xq_reg, yq_reg;

    logic [CW-1:0]   xsh, ysh, xr, yr;
    logic            xtake, ytake;

    // Compare each remainder with its divisor at this cell's weight
    assign xsh   = CW'(in_xdiv) << SHIFT;
    assign ysh   = CW'(in_ydiv) << SHIFT;
    assign xr    = CW'(in_xrem);
    assign yr    = CW'(in_yrem);
    assign xtake = xr >= xsh;
    assign ytake = yr >= ysh;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctx_reg  <= in_ctx;
            xdiv_reg <= in_xdiv;
            ydiv_reg <= in_ydiv;
            xrem_reg <= xtake ? DW'(xr - xsh) : in_xrem;
            yrem_reg <= ytake ? DW'(yr - ysh) : in_yrem;
            xq_reg   <= {in_xq[QW-2:0], xtake};
            yq_reg   <= {in_yq[QW-2:0], ytake};
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_xrem  = xrem_reg;
    assign out_xdiv  = xdiv_reg;
    assign out_xq    = xq_reg;
    assign out_yrem  = yrem_reg;
    assign out_ydiv  = ydiv_reg;
    assign out_yq    = yq_reg;

endmodule

`default_nettype wire

@@ test/quadratic_root_solver_core_test.sv @@
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 100ps

module quadratic_root_solver_core_test;

    localparam int ONE        = 65536;
    localparam int LATENCY    = 72;
    localparam int LIMIT      = 400000;
    localparam int PHASE_LEN  = 250;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic               valid_first;
        logic               valid_second;
        logic               ovf;
    } roots_t;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               typed;
        roots_t             want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [qrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qrs_pkg::CLIP_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [qrs_pkg::MAG_W-1:0] coef_a = '0;
    logic signed [qrs_pkg::MAG_W-1:0] coef_b = '0;
    logic signed [qrs_pkg::MAG_W-1:0] coef_c = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [qrs_pkg::MAG_W-1:0] root_first;
    logic signed [qrs_pkg::MAG_W-1:0] root_second;
    logic first_valid;
    logic second_valid;
    logic overflow;

    // Local copy of the configuration
    logic [15:0] clip_level = 16'd1;
    logic        ascending_order = 1'b1;

    roots_t pending_roots[$];
    int     errors = 0;
    int     sent_count = 0;
    int     cycle = 0;
    logic   sender_calm = 1'b0;
    int     hold_left = 0;
    logic   hold_done = 1'b0;

    quadratic_root_solver_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .out_valid(out_valid), .out_ready(out_ready),
        .root_first(root_first), .root_second(root_second),
        .first_valid(first_valid), .second_valid(second_valid),
        .overflow(overflow)
    );

    always #1 clk = ~clk;

    // Floor square root of a wide value
    function automatic logic [127:0] floor_sqrt(input logic [127:0] d);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int i = 36; i >= 0; i--)
        begin
            cand = res | (128'd1 << i);
            if (cand * cand <= d)
                res = cand;
        end
        return res;
    endfunction

    // Clamp a signed magnitude to 32 bits, flag saturation
    function automatic logic signed [31:0] clamp_root(input logic neg, input logic [127:0] mag,
                                                    inout logic ovf);
        if (neg)
        begin
            if (mag > 128'h8000_0000)
            begin
                ovf = 1'b1;
                return S_MIN;
            end
            return -$signed(mag[32:0]);
        end
        if (mag > 128'h7FFF_FFFF)
        begin
            ovf = 1'b1;
            return S_MAX;
        end
        return $signed(mag[31:0]);
    endfunction

    function automatic roots_t solve_quadratic(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
        logic an, bn, cn, ok, ovf, n1, n2, dneg;
        logic [127:0] am, bm, cm, m1, m2, bb, p4, d, s, twoq, qa, cq;
        logic signed [31:0] v1, v2, t;
        roots_t r;
        an = a[31]; bn = b[31]; cn = c[31];
        am = an ? (128'd1 << 32) - {96'd0, a} : {96'd0, a};
        bm = bn ? (128'd1 << 32) - {96'd0, b} : {96'd0, b};
        cm = cn ? (128'd1 << 32) - {96'd0, c} : {96'd0, c};
        ok = 1'b1; ovf = 1'b0; n1 = 1'b0; n2 = 1'b0; m1 = '0; m2 = '0; dneg = 1'b0;
        if (am == 0 && bm == 0)
            ok = 1'b0;
        else if (am == 0)
        begin
            m1 = (cm << 16) / bm;
            n1 = (cm != 0) && (cn == bn);
            m2 = m1; n2 = n1;
        end
        else if (cm == 0)
        begin
            if (bm != 0 && bn)
            begin
                m1 = (bm << 16) / am;
                n1 = an == bn;
            end
            else
            begin
                m2 = (bm << 16) / am;
                n2 = (bm != 0) && (an == bn);
            end
        end
        else if (bm == 0)
        begin
            if (an == cn)
            begin
                if (!((cm << 16) < clip_level * am))
                    ok = 1'b0;
            end
            else
            begin
                s = floor_sqrt(am * cm);
                m1 = (s << 16) / am;
                n1 = an;
                m2 = m1;
                n2 = !an;
            end
        end
        else
        begin
            bb = bm * bm;
            p4 = (am * cm) << 2;
            if (an != cn)
                d = bb + p4;
            else if (bb >= p4)
                d = bb - p4;
            else
            begin
                d = p4 - bb;
                dneg = 1'b1;
            end
            // Clip a slightly negative discriminant to zero
            if (dneg)
            begin
                if (d < ({112'd0, clip_level} << 16))
                    d = '0;
                else
                    ok = 1'b0;
            end
            if (ok && d == 0)
            begin
                m1 = (bm << 16) / (2 * am);
                n1 = an == bn;
                m2 = m1; n2 = n1;
            end
            else if (ok)
            begin
                s = floor_sqrt(d);
                twoq = bm + s;
                qa = (twoq << 16) / (2 * am);
                cq = (cm << 17) / twoq;
                if (bn)
                begin
                    m1 = qa; n1 = an == bn; m2 = cq; n2 = cn == bn;
                end
                else
                begin
                    m1 = cq; n1 = cn == bn; m2 = qa; n2 = an == bn;
                end
            end
        end
        v1 = '0; v2 = '0;
        if (ok)
        begin
            v1 = clamp_root(n1, m1, ovf);
            v2 = clamp_root(n2, m2, ovf);
            if (ascending_order)
            begin
                if (v1 >= 0 && v2 >= 0)
                begin
                    if (v1 > v2)
                    begin
                        t = v1; v1 = v2; v2 = t;
                    end
                end
                else if (v1 < 0)
                begin
                    t = v1; v1 = v2; v2 = t;
                end
            end
        end
        r.first = v1; r.second = v2; r.valid_first = ok; r.valid_second = ok; r.ovf = ovf;
        return r;
    endfunction

    // Write both registers on consecutive edges
    task automatic set_config(input logic [15:0] clip, input logic order);
        cfg_write <= 1'b1;
        cfg_index <= qrs_pkg::REG_CLIP;
        cfg_data <= clip;
        @(posedge clk);
        cfg_index <= qrs_pkg::REG_ORDER;
        cfg_data <= {15'd0, order};
        @(posedge clk);
        cfg_write <= 1'b0;
        clip_level = clip;
        ascending_order = order;
    endtask

    // Offer one triple and hold it until the transfer
    task automatic send_coefs(input logic signed [31:0] a, input logic signed [31:0] b,
                              input logic signed [31:0] c, input logic typed,
                              input roots_t want);
        while (!sender_calm && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        do
            @(posedge clk);
        while (!in_ready);
        pending_roots.push_back(typed ? want : solve_quadratic(a, b, c));
        sent_count++;
    endtask

    function automatic logic signed [31:0] random_coef();
        case ($urandom_range(9))
            0: return '0;
            1:
            begin
                case ($urandom_range(3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            2: return $signed($urandom_range(511)) - 256;
            3, 4: return ($signed($urandom_range(64)) - 32) * ONE;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int count);
        logic signed [31:0] a, b, c;
        logic signed [31:0] k;
        roots_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            sender_calm = (i >= 80 && i < 140);
            if ($urandom_range(3) == 0)
            begin
                // Near a double root: b close to +/-2k, a = c = k
                k = $signed($urandom_range(1, 20000));
                if ($urandom_range(1)) k = -k;
                a = k;
                c = k;
                b = 2 * k + $signed($urandom_range(6)) - 3;
                if ($urandom_range(1)) b = -b;
            end
            else
            begin
                a = random_coef();
                b = random_coef();
                c = random_coef();
            end
            send_coefs(a, b, c, 1'b0, none);
        end
        sender_calm = 1'b0;
    endtask

    task automatic drain();
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // Receiver: random stalls, one calm stretch, one long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && sent_count >= 700)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (cycle >= 3000 && cycle < 4500) || $urandom_range(99) >= 19;
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        roots_t w;
        if (out_valid && out_ready)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected result %h %h", $time, root_first, root_second);
                errors++;
            end
            else
            begin
                w = pending_roots.pop_front();
                if (root_first !== w.first)
                begin
                    $display("%0t: root_first expected %h actual %h", $time, w.first, root_first);
                    errors++;
                end
                if (root_second !== w.second)
                begin
                    $display("%0t: root_second expected %h actual %h", $time, w.second,
                             root_second);
                    errors++;
                end
                if (first_valid !== w.valid_first)
                begin
                    $display("%0t: first_valid expected %b actual %b", $time, w.valid_first,
                             first_valid);
                    errors++;
                end
                if (second_valid !== w.valid_second)
                begin
                    $display("%0t: second_valid expected %b actual %b", $time, w.valid_second,
                             second_valid);
                    errors++;
                end
                if (overflow !== w.ovf)
                begin
                    $display("%0t: overflow expected %b actual %b", $time, w.ovf, overflow);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("FAIL quadratic_root_solver_core");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        roots_t z;
        z = '{default: '0};
        // Directed rows under reset configuration; typed where obvious
        rows = '{
            '{0, 0, 0, 1, '{0, 0, 0, 0, 0}},
            '{0, 0, ONE, 1, '{0, 0, 0, 0, 0}},
            '{0, ONE, -2 * ONE, 1, '{2 * ONE, 2 * ONE, 1, 1, 0}},
            '{ONE, -3 * ONE, 0, 1, '{0, 3 * ONE, 1, 1, 0}},
            '{ONE, 0, -4 * ONE, 1, '{2 * ONE, -2 * ONE, 1, 1, 0}},
            '{ONE, 0, ONE, 1, '{0, 0, 0, 0, 0}},
            '{S_MAX, 0, 1, 1, '{0, 0, 1, 1, 0}},
            '{ONE, 2 * ONE, ONE, 1, '{-ONE, -ONE, 1, 1, 0}},
            '{ONE, ONE, ONE, 1, '{0, 0, 0, 0, 0}},
            '{1, 1, 1, 1, '{-32768, -32768, 1, 1, 0}},
            '{1, S_MAX, 0, 1, '{0, S_MIN, 1, 1, 1}},
            '{0, 1, S_MIN, 1, '{S_MAX, S_MAX, 1, 1, 1}},
            '{ONE, -3 * ONE, 2 * ONE, 0, z},
            '{-ONE, 5 * ONE, 7 * ONE, 0, z},
            '{S_MIN, S_MIN, S_MIN, 0, z},
            '{S_MAX, S_MAX, S_MAX, 0, z},
            '{S_MIN, S_MAX, S_MIN, 0, z},
            '{S_MIN, 0, S_MAX, 0, z},
            '{0, S_MIN, S_MAX, 0, z},
            '{-1, -1, -1, 0, z},
            '{S_MAX, S_MIN, 1, 0, z},
            '{3, -7, 2, 0, z}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].want);
        in_valid <= 1'b0;
        drain();

        // Random phases across register settings, extremes included
        set_config(16'd0, 1'b0);
        run_random(PHASE_LEN);
        in_valid <= 1'b0;
        drain();
        set_config(16'hFFFF, 1'b1);
        run_random(PHASE_LEN);
        in_valid <= 1'b0;
        drain();
        set_config(16'hFFFF, 1'b0);
        run_random(PHASE_LEN);
        in_valid <= 1'b0;
        drain();
        set_config(16'($urandom), 1'($urandom));
        run_random(PHASE_LEN);
        in_valid <= 1'b0;
        drain();
        set_config(16'd1, 1'b1);
        run_random(PHASE_LEN);
        in_valid <= 1'b0;
        drain();

        if (errors == 0 && pending_roots.size() == 0)
            $display("PASS quadratic_root_solver_core");
        else
            $display("FAIL quadratic_root_solver_core");
        $finish;
    end

endmodule
